// ===== rtl/core/ahdlc_pkg.sv =====
package ahdlc_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [1:0] phase_t;

  localparam kind_t KIND_DATA   = 3'd0;
  localparam kind_t KIND_GOOD   = 3'd1;
  localparam kind_t KIND_FCS    = 3'd2;
  localparam kind_t KIND_BADESC = 3'd3;
  localparam kind_t KIND_LONG   = 3'd4;

  localparam phase_t PH_HUNT  = 2'd0;
  localparam phase_t PH_FRAME = 2'd1;
  localparam phase_t PH_ESC   = 2'd2;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_FLAG  = 8'h5e;
  localparam logic [7:0] ESC_ESC   = 8'h5d;

  localparam logic [15:0] FCS_POLY = 16'h8408;
  localparam logic [15:0] FCS_SEED = 16'hffff;
  localparam logic [15:0] FCS_GOOD = 16'hf0b8;

  localparam logic [7:0] MAX_LEN_RST = 8'd94;

  function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/async_hdlc_deframer_fcs16.sv =====
// Asynchronous HDLC receive deframer with 16-bit FCS check.
// Input channel: one raw line byte per beat on rx_byte_i (in_valid_i/in_ready_o).
// Output channel: one result per beat on data_byte_o, kind_o, last_o
// (out_valid_o/out_ready_i). Kind 0 carries a decoded byte; kinds 1 to 4 are
// end markers (good, FCS error, bad escape, too long) with last_o high.
// Bytes outside a frame, escape prefixes, opening and repeated flags give no beat.
// Path: each accepted beat is held in the input register, and its result is
// then written to the result register once that is free or being taken.
// Throughput: one input beat per cycle while results are taken, set by the
// byte-wide CRC update and escape decode between the two registers.
// Reset: both registers empty, hunting for an opening flag, FCS seeded to
// 0xFFFF, max_len 94. Outside reset, cfg_we_i writes max_len in the same edge.
// Stall: while out_ready_i is low and a result waits, the input register
// holds its byte and in_ready_o drops once it is full; nothing is lost.
module async_hdlc_deframer_fcs16 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           data_byte_o,
  output ahdlc_pkg::kind_t     kind_o,
  output logic                 last_o
);
  import ahdlc_pkg::*;

  logic [7:0]  max_len_q;
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  phase_t      phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q;
  kind_t       out_kind_q;
  logic        out_last_q;

  logic        s1_adv;
  logic        res_valid;
  logic [7:0]  res_data;
  kind_t       res_kind;
  logic        res_last;
  logic [7:0]  take_byte;
  logic        take;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    crc_d     = crc_q;
    res_valid = 1'b0;
    res_data  = 8'h00;
    res_kind  = KIND_DATA;
    res_last  = 1'b0;
    take      = 1'b0;
    take_byte = s1_byte_q;
    case (phase_q)
      PH_FRAME: begin
        if (s1_byte_q == FLAG_BYTE) begin
          if (count_q != 8'd0) begin
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_kind  = (crc_q == FCS_GOOD) ? KIND_GOOD : KIND_FCS;
            phase_d   = PH_HUNT;
          end
        end else if (count_q >= max_len_q) begin
          res_valid = 1'b1;
          res_last  = 1'b1;
          res_kind  = KIND_LONG;
          phase_d   = PH_HUNT;
        end else if (s1_byte_q == ESC_BYTE) begin
          phase_d = PH_ESC;
        end else begin
          take = 1'b1;
        end
      end
      PH_ESC: begin
        if (s1_byte_q == ESC_FLAG) begin
          take      = 1'b1;
          take_byte = FLAG_BYTE;
        end else if (s1_byte_q == ESC_ESC) begin
          take      = 1'b1;
          take_byte = ESC_BYTE;
        end else begin
          res_valid = 1'b1;
          res_last  = 1'b1;
          res_kind  = KIND_BADESC;
          phase_d   = PH_HUNT;
        end
      end
      default: begin
        if (s1_byte_q == FLAG_BYTE) begin
          phase_d = PH_FRAME;
          count_d = 8'd0;
          crc_d   = FCS_SEED;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase
    if (take) begin
      crc_d     = fcs_update(crc_q, take_byte);
      count_d   = count_q + 8'd1;
      phase_d   = PH_FRAME;
      res_valid = 1'b1;
      res_data  = take_byte;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MAX_LEN_RST;
      s1_valid_q  <= 1'b0;
      phase_q     <= PH_HUNT;
      count_q     <= 8'd0;
      crc_q       <= FCS_SEED;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        phase_q <= phase_d;
        count_q <= count_d;
        crc_q   <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s1_adv && res_valid) begin
      out_data_q <= res_data;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = out_data_q;
  assign kind_o      = out_kind_q;
  assign last_o      = out_last_q;

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_kind_q != KIND_DATA)))
    else $error("last flag disagrees with result kind");

  a_marker_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != KIND_DATA) |-> (out_data_q == 8'h00))
    else $error("end marker carries nonzero data");

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("unused phase code reached");

  a_end_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && res_valid && res_last) |=> (phase_q == PH_HUNT))
    else $error("block did not hunt after an end marker");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a waiting result");

endmodule
